FILE: src/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared constants and types for the waterfall quantiser.
// ----------------------------------------------------------------------------
package swq_pkg;

	localparam int BINS_PER_FRAME = 206;
	localparam int HISTORY_FRAMES = 10;
	localparam int MEM_DEPTH      = BINS_PER_FRAME * HISTORY_FRAMES;
	localparam int ADDR_W         = $clog2(MEM_DEPTH);
	localparam int POS_W          = $clog2(BINS_PER_FRAME);
	localparam int SLOT_W         = $clog2(HISTORY_FRAMES);
	localparam int MAG_W          = 48;
	localparam int SUM_W          = MAG_W + 4;
	localparam int DB_W           = 18;

	localparam logic signed [DB_W-1:0] DB_FLOOR    = -18'sd51200;
	localparam logic signed [DB_W-1:0] LOWER_RESET = -18'sd20480;
	localparam logic [17:0] TEN_LOG10_2 = 18'd197283;
	localparam logic [10:0] AGC_FACTOR  = 11'd1311;

	localparam logic [1:0] REG_AVG_LEN = 2'd0;
	localparam logic [1:0] REG_REF     = 2'd1;
	localparam logic [1:0] REG_UPPER   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_READ,
		ST_DIV,
		ST_NORM,
		ST_LOG,
		ST_DB,
		ST_CLAMP,
		ST_CODE,
		ST_OUT,
		ST_AGC
	} state_t;

endpackage

FILE: src/spectrum_waterfall_quantizer.sv
// ----------------------------------------------------------------------------
// spectrum_waterfall_quantizer
// Averaged log-power 4-bit waterfall quantiser over a ten-frame history RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted bin is written, the n frames averaged are read back and
//   summed, then a serial divide, the log, a clamp, a serial code divide, output.
// Input: a bin is taken only once the one before has passed ST_OUT (and ST_AGC
//   at frame end) and not while a byte is held; the divider and log set the pace.
// Reset: a clearing pass zeroes all 2060 history RAM entries, one entry a
//   cycle; no bin is accepted meanwhile. Registers take their reset values.
module spectrum_waterfall_quantizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [swq_pkg::MAG_W-1:0]   magnitude_sq,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  packed_pair,
	output logic                        frame_last,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [16:0]                 cfg_data
);
	import swq_pkg::*;

	state_t state_q, state_d;

	logic [3:0]             avg_len_q;
	logic [15:0]            ref_q;
	logic signed [DB_W-1:0] upper_q;
	logic signed [DB_W-1:0] lower_q, fmin_q, fmax_q;
	logic [SLOT_W-1:0]      slot_q, rd_slot_q;
	logic [POS_W-1:0]       pos_q;
	logic [3:0]             hnib_q, n_q, rd_cnt_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [MAG_W-1:0]       mag_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   rd_pend_q;
	logic signed [DB_W-1:0] v_q, lo_q, hi_q;
	logic [35:0]            dbp_q;
	logic [3:0]             code_val, cd_cnt_q;
	logic [DB_W+5:0]        num_q;
	logic [DB_W:0]          d2_q;
	logic [4:0]             quo_q;
	logic                   last_q;

	// RAM port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [MAG_W-1:0]  ram_wdata, ram_rdata;

	swq_ram #(.WIDTH(MAG_W), .DEPTH(MEM_DEPTH)) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	logic             div_start, div_done;
	logic [SUM_W-1:0] div_q;
	swq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_q),
		.divisor(n_q), .done(div_done), .quotient(div_q)
	);

	logic        log_start, log_done;
	logic [17:0] log_val;
	swq_log u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start),
		.x({1'b0, div_q[MAG_W-1:0]} + {{MAG_W{1'b0}}, 1'b1}),
		.done(log_done), .log2_q12(log_val)
	);

	// effective frame count, saturated into range
	logic [3:0] n_eff;
	always_comb begin
		n_eff = avg_len_q;
		if (n_eff == 4'd0) n_eff = 4'd1;
		if (n_eff > 4'(HISTORY_FRAMES)) n_eff = 4'(HISTORY_FRAMES);
	end

	logic [SLOT_W-1:0] slot_next;
	assign slot_next = (slot_q == SLOT_W'(HISTORY_FRAMES - 1)) ? '0 : slot_q + 1'b1;

	logic [SLOT_W-1:0] slot_use;
	assign slot_use = (pos_q == '0) ? slot_next : slot_q;

	logic [ADDR_W-1:0] base_addr, rd_addr;
	assign base_addr = ADDR_W'(slot_use) * ADDR_W'(BINS_PER_FRAME) + ADDR_W'(pos_q);
	assign rd_addr   = ADDR_W'(rd_slot_q) * ADDR_W'(BINS_PER_FRAME) + ADDR_W'(pos_q);

	logic [SLOT_W-1:0] rd_slot_prev;
	assign rd_slot_prev = (rd_slot_q == '0) ? SLOT_W'(HISTORY_FRAMES - 1) : rd_slot_q - 1'b1;

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign in_acc   = in_valid && !in_stall;

	logic signed [DB_W-1:0] db_val, v_raw;
	assign db_val = DB_W'(signed'({1'b0, dbp_q[35:20]}));
	assign v_raw  = db_val - DB_W'(signed'({2'b0, ref_q}));

	// code step: one quotient bit per cycle from a 5-bit shift subtract
	logic [DB_W+5:0] d2_sh;
	assign d2_sh = {5'd0, d2_q} << cd_cnt_q;

	// lower-limit update
	logic signed [DB_W+1:0] agc_t;
	logic signed [DB_W+13:0] agc_p;
	assign agc_t = (DB_W+2)'(fmin_q) + (DB_W+2)'(signed'({1'b0, (4'd10 - n_q), 8'd0}))
		- (DB_W+2)'(lower_q);
	assign agc_p = (DB_W+14)'(agc_t) * (DB_W+14)'(signed'({1'b0, AGC_FACTOR}))
		+ (DB_W+14)'(32768);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = rd_addr;
		ram_wdata = mag_q;
		div_start = 1'b0;
		log_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: if (in_acc) state_d = ST_WRITE;
			ST_WRITE: begin
				ram_we   = 1'b1;
				ram_addr = base_addr;
				state_d  = ST_READ;
			end
			ST_READ: if (rd_cnt_q == '0 && !rd_pend_q) begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: if (div_done) begin
				log_start = 1'b1;
				state_d   = ST_NORM;
			end
			ST_NORM: if (log_done) state_d = ST_DB;
			ST_LOG:  state_d = ST_DB;
			ST_DB:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_CODE;
			ST_CODE: if (cd_cnt_q == '0) state_d = ST_OUT;
			ST_OUT:  state_d = last_q ? ST_AGC : ST_IDLE;
			ST_AGC:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			avg_len_q <= 4'd1;
			ref_q     <= 16'd34714;
			upper_q   <= -18'sd2560;
			lower_q   <= LOWER_RESET;
			fmin_q    <= '0;
			fmax_q    <= DB_FLOOR;
			slot_q    <= '0;
			pos_q     <= '0;
			hnib_q    <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AVG_LEN: avg_len_q <= cfg_data[3:0];
					REG_REF:     ref_q     <= cfg_data[15:0];
					REG_UPPER:   upper_q   <= DB_W'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_WRITE: begin
					if (pos_q == '0) begin
						slot_q <= slot_next;
						fmin_q <= '0;
						fmax_q <= DB_FLOOR;
					end
					rd_slot_q <= slot_use;
					rd_cnt_q  <= n_eff;
					rd_pend_q <= 1'b0;
				end
				ST_READ: begin
					// issue one read a cycle; accumulate its data in the cycle after
					rd_pend_q <= rd_cnt_q != '0;
					if (rd_cnt_q != '0) begin
						rd_cnt_q  <= rd_cnt_q - 1'b1;
						rd_slot_q <= rd_slot_prev;
					end
				end
				ST_DB: begin
					if (v_raw > fmax_q) fmax_q <= v_raw;
					else if (v_raw < fmin_q) fmin_q <= v_raw;
				end
				ST_OUT: begin
					if (!pos_q[0]) hnib_q <= code_val;
					if (pos_q[0] || last_q) begin
						out_valid   <= 1'b1;
					end
					pos_q <= last_q ? '0 : pos_q + 1'b1;
				end
				ST_AGC: lower_q <= lower_q + DB_W'(agc_p >>> 16);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) mag_q <= magnitude_sq;
		if (state_q == ST_WRITE) begin
			sum_q <= '0;
			n_q   <= n_eff;
			last_q <= pos_q == POS_W'(BINS_PER_FRAME - 1);
		end
		if (state_q == ST_READ && rd_pend_q) sum_q <= sum_q + SUM_W'(ram_rdata);
		if (log_done) dbp_q <= 36'(log_val) * 36'(TEN_LOG10_2) + 36'(1 << 19);
		if (state_q == ST_DB) begin
			v_q  <= v_raw;
			lo_q <= lower_q;
			hi_q <= upper_q;
		end
		if (state_q == ST_CLAMP) begin
			// clamp, then set up (v-lo)*30 + d over 2d
			if (v_q > hi_q) begin
				num_q <= (DB_W+6)'((hi_q - lo_q) * 30 + (hi_q - lo_q));
			end else if (v_q < lo_q) begin
				num_q <= (DB_W+6)'(hi_q - lo_q);
			end else begin
				num_q <= (DB_W+6)'((v_q - lo_q) * 30 + (hi_q - lo_q));
			end
			d2_q     <= (DB_W+1)'((hi_q - lo_q) * 2);
			cd_cnt_q <= 4'd4;
			quo_q    <= '0;
		end
		if (state_q == ST_CODE) begin
			if (num_q >= d2_sh) begin
				num_q <= num_q - d2_sh;
				quo_q <= {quo_q[3:0], 1'b1};
			end else begin
				quo_q <= {quo_q[3:0], 1'b0};
			end
			if (cd_cnt_q != '0) cd_cnt_q <= cd_cnt_q - 1'b1;
		end
		if (state_q == ST_OUT) begin
			packed_pair <= pos_q[0] ? {hnib_q, code_val} : {code_val, 4'd0};
			frame_last  <= last_q;
		end
	end

	// final code: saturate, zero when the window is empty
	always_comb begin
		code_val = (quo_q > 5'd15) ? 4'd15 : quo_q[3:0];
		if (hi_q <= lo_q) code_val = '0;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("bin taken while busy");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(BINS_PER_FRAME))
		else $error("bin position out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(packed_pair)))
		else $error("result dropped under stall");
endmodule

FILE: src/swq_ram.sv
// ----------------------------------------------------------------------------
// swq_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module swq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: src/swq_div.sv
// ----------------------------------------------------------------------------
// swq_div
// Restoring divider, one quotient bit per cycle (sum over frame count).
// ----------------------------------------------------------------------------
module swq_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swq_pkg::SUM_W-1:0]  dividend,
	input  logic [3:0]                 divisor,
	output logic                       done,
	output logic [swq_pkg::SUM_W-1:0]  quotient
);
	import swq_pkg::*;

	logic [SUM_W-1:0] q_q;
	logic [4:0]       rem_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [4:0]       trial;
	logic             ge;

	assign trial = {rem_q[3:0], q_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, divisor}) : trial;
			q_q   <= {q_q[SUM_W-2:0], ge};
		end
	end

	assign quotient = q_q;
endmodule

FILE: src/swq_log.sv
// ----------------------------------------------------------------------------
// swq_log
// log2 in Q12: leading-one search then twelve squaring steps, one a cycle.
// ----------------------------------------------------------------------------
module swq_log (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swq_pkg::MAG_W:0]    x,
	output logic                       done,
	output logic [17:0]                log2_q12
);
	import swq_pkg::*;

	logic [MAG_W:0]  x_q;
	logic [5:0]      e_q;
	logic [31:0]     m_q;
	logic [11:0]     frac_q;
	logic [3:0]      cnt_q;
	logic [1:0]      phase_q;
	logic [63:0]     sq;
	logic [33:0]     sq_sh;
	logic [5:0]      lead;
	logic [78:0]     xs;

	// index of the leading one; the highest set bit wins
	always_comb begin
		lead = '0;
		for (int i = 0; i <= MAG_W; i++) begin
			if (x_q[i]) begin
				lead = 6'(i);
			end
		end
	end

	assign xs    = {30'd0, x_q} << 30;
	assign sq    = m_q * m_q;
	assign sq_sh = sq[63:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				phase_q <= 2'd1;
			end else if (phase_q == 2'd1) begin
				phase_q <= 2'd2;
				cnt_q   <= 4'd12;
			end else if (phase_q == 2'd2) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					phase_q <= 2'd0;
					done    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
		end else if (phase_q == 2'd1) begin
			e_q    <= lead;
			m_q    <= 32'(xs >> lead);
			frac_q <= '0;
		end else if (phase_q == 2'd2) begin
			if (sq_sh[31]) begin
				m_q    <= sq_sh[32:1];
				frac_q <= {frac_q[10:0], 1'b1};
			end else begin
				m_q    <= sq_sh[31:0];
				frac_q <= {frac_q[10:0], 1'b0};
			end
		end
	end

	assign log2_q12 = {e_q, frac_q};
endmodule

FILE: tb/sv/spectrum_waterfall_quantizer_tb.sv
// ----------------------------------------------------------------------------
// spectrum_waterfall_quantizer_tb
// Self-checking bench: streams FFT bin powers through the quantiser across
// several register settings, predicts every packed byte in step with the
// accepted bins and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module spectrum_waterfall_quantizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swq_pkg::*;

	// Index with no register behind it; writes here must be ignored.
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [7:0] pair;
		logic       last;
	} pair_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [MAG_W-1:0]     magnitude_sq = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b1;
	logic [7:0]           packed_pair;
	logic                 frame_last;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = REG_AVG_LEN;
	logic [16:0]          cfg_data = '0;

	// Bins waiting to be offered, bytes waiting to come out.
	logic [MAG_W-1:0] bin_q[$];
	pair_t            pair_q[$];

	int  errors = 0;
	bit  calm = 1'b0;       // no idling on either side while set
	bit  long_req = 1'b0;   // ask the receiver for one long hold-off
	int  send_wait = 0;
	int  hold_cnt = 0;
	int  quiet_cycles = 0;

	// Predictor state: its own copy of the history ring and the registers.
	logic [MAG_W-1:0] hist_ram[0:MEM_DEPTH-1];
	int  slot_now = 0;
	int  bin_pos = 0;
	longint lower_lim = -20480;
	longint fmin = 0;
	longint fmax = -51200;
	logic [3:0] high_nib = '0;
	int  avg_reg = 1;
	int  ref_reg = 34714;
	longint upper_reg = -2560;

	spectrum_waterfall_quantizer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .magnitude_sq(magnitude_sq),
		.out_valid(out_valid), .out_stall(out_stall),
		.packed_pair(packed_pair), .frame_last(frame_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// log2 in Q12: leading-one index, then twelve squarings of the Q30 mantissa.
	function automatic longint log2_fix(logic [63:0] x);
		int e;
		logic [63:0] m;
		longint frac;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		if (e <= 30)
			m = x << (30 - e);
		else
			m = x >> (e - 30);
		for (int k = 0; k < 12; k++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(e) << 12) | frac;
	endfunction

	// Advance the predictor by one bin and queue the byte it yields, if any.
	function automatic void predict_pair(logic [MAG_W-1:0] mag);
		int n, pos, s;
		logic [63:0] total;
		longint db, v, d, num, q, t, p;
		logic [3:0] code;
		bit last;
		pair_t r;
		n = (avg_reg < 1) ? 1 : (avg_reg > HISTORY_FRAMES) ? HISTORY_FRAMES : avg_reg;
		pos = (bin_pos >= BINS_PER_FRAME) ? 0 : bin_pos;
		if (pos == 0) begin
			slot_now = (slot_now + 1) % HISTORY_FRAMES;
			fmin = 0;
			fmax = -51200;
		end
		hist_ram[slot_now * BINS_PER_FRAME + pos] = mag;
		total = '0;
		for (int i = 0; i < n; i++) begin
			s = (slot_now + HISTORY_FRAMES - i) % HISTORY_FRAMES;
			total += hist_ram[s * BINS_PER_FRAME + pos];
		end
		total = total / n;
		db = (log2_fix(total + 1) * 197283 + (64'd1 << 19)) >>> 20;
		v = db - ref_reg;
		if (v > fmax)
			fmax = v;
		else if (v < fmin)
			fmin = v;
		if (v > upper_reg)
			v = upper_reg;
		else if (v < lower_lim)
			v = lower_lim;
		if (upper_reg <= lower_lim) begin
			code = 4'd0;
		end else begin
			d = upper_reg - lower_lim;
			num = (v - lower_lim) * 30 + d;
			q = (num >= 0) ? num / (2 * d) : 0;
			code = (q > 15) ? 4'd15 : q[3:0];
		end
		last = (pos + 1 >= BINS_PER_FRAME);
		if ((pos & 1) == 0) begin
			high_nib = code;
			if (last) begin
				r.pair = {high_nib, 4'd0};
				r.last = 1'b1;
				pair_q.push_back(r);
			end
		end else begin
			r.pair = {high_nib, code};
			r.last = last;
			pair_q.push_back(r);
		end
		if (last) begin
			// Nudge the lower limit about 2 % toward the frame floor.
			t = fmin + longint'(10 - n) * 256;
			p = 1311 * (t - lower_lim);
			lower_lim = lower_lim + ((p + 32768) >>> 16);
			bin_pos = 0;
		end else begin
			bin_pos = pos + 1;
		end
	endfunction

	function automatic int draw_idle();
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	// Mix of exact zero, full scale, small values and wide random spans.
	function automatic logic [MAG_W-1:0] draw_mag();
		logic [63:0] w;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {MAG_W{1'b1}};
			2: return MAG_W'($urandom_range(0, 255));
			default: begin
				w = {$urandom, $urandom};
				return MAG_W'(w >> $urandom_range(0, 63));
			end
		endcase
	endfunction

	// Driver: offer bins from the queue; hold the payload while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_pair(magnitude_sq);
			if (!(in_valid && in_stall)) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (bin_q.size() != 0) begin
					in_valid <= 1'b1;
					magnitude_sq <= bin_q.pop_front();
					send_wait <= draw_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		int n;
		pair_t e;
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_cnt <= 0;
		end else begin
			n = hold_cnt;
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual pair=%02h last=%0b",
						$time, packed_pair, frame_last);
					errors++;
				end else begin
					e = pair_q.pop_front();
					if (packed_pair !== e.pair) begin
						$display("%0t: packed_pair mismatch: expected %02h, actual %02h",
							$time, e.pair, packed_pair);
						errors++;
					end
					if (frame_last !== e.last) begin
						$display("%0t: frame_last mismatch: expected %0b, actual %0b",
							$time, e.last, frame_last);
						errors++;
					end
				end
				n = draw_idle();
			end
			if (long_req) begin
				n = LONG_HOLD;
				long_req <= 1'b0;
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				hold_cnt <= n - 1;
			end else begin
				out_stall <= 1'b0;
				hold_cnt <= 0;
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("spectrum_waterfall_quantizer verification failed");
			$finish;
		end
	end

	// Write one register and mirror it in the predictor; only while idle.
	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_AVG_LEN: avg_reg = val[3:0];
			REG_REF:     ref_reg = val[15:0];
			REG_UPPER:   upper_reg = longint'($signed(val));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every bin is sent and every byte is out, then let the pipe drain.
	task automatic drain();
		wait (bin_q.size() == 0 && !in_valid && pair_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++)
			bin_q.push_back(draw_mag());
	endtask

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++)
			hist_ram[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and single bits at reset settings.
		bin_q.push_back('0);
		bin_q.push_back({MAG_W{1'b1}});
		bin_q.push_back(48'd1);
		bin_q.push_back({MAG_W{1'b1}} - 1);
		bin_q.push_back(48'd2);
		bin_q.push_back(48'd3);
		for (int b = 0; b < MAG_W; b += 3)
			bin_q.push_back(MAG_W'(1) << b);
		bin_q.push_back(48'h5555_5555_5555);
		bin_q.push_back(48'hAAAA_AAAA_AAAA);
		drain();

		// Longest average, no reference, ceiling at 0 dB.
		write_reg(REG_AVG_LEN, 17'd10);
		write_reg(REG_REF, 17'd0);
		write_reg(REG_UPPER, 17'd0);
		queue_random(412);
		drain();

		// Ceiling at the floor so the code stays 0; zero length saturates up.
		write_reg(REG_AVG_LEN, 17'd0);
		write_reg(REG_REF, 17'd51200);
		write_reg(REG_UPPER, 17'(-51200));
		write_reg(REG_NONE, 17'h1FFFF);
		queue_random(206);
		drain();

		// Oversized length saturates down; a long receiver hold fills the block.
		write_reg(REG_AVG_LEN, 17'd15);
		write_reg(REG_REF, 17'd34714);
		write_reg(REG_UPPER, 17'(-2560));
		queue_random(412);
		long_req <= 1'b1;
		drain();

		// Random mid settings with both sides running flat out.
		calm = 1'b1;
		write_reg(REG_AVG_LEN, 17'($urandom_range(2, 9)));
		write_reg(REG_REF, 17'($urandom_range(0, 51200)));
		write_reg(REG_UPPER, 17'(-$signed($urandom_range(0, 51200))));
		queue_random(412);
		drain();
		calm = 1'b0;

		// Full-width reference and a positive ceiling.
		write_reg(REG_AVG_LEN, 17'd1);
		write_reg(REG_REF, 17'd65535);
		write_reg(REG_UPPER, 17'd65535);
		queue_random(200);
		drain();
		write_reg(REG_AVG_LEN, 17'd3);
		write_reg(REG_REF, 17'd25600);
		write_reg(REG_UPPER, 17'(-10000));
		queue_random(200);
		drain();

		if (errors == 0)
			$display("spectrum_waterfall_quantizer verification clean");
		else
			$display("spectrum_waterfall_quantizer verification failed");
		$finish;
	end

endmodule
